/* hw/rtl/bounded_deque_with_readout_top_macros.svh */
// ----------------------------------------------------------------------------
// Bounded deque assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_READOUT_TOP_MACROS_SVH
`define BOUNDED_DEQUE_WITH_READOUT_TOP_MACROS_SVH

// Property that must hold in the same cycle as its trigger.
`define BDQ_ASSERT_NOW(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
        else $error(msg);

// Property that must hold in the cycle after its trigger.
`define BDQ_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

/* hw/rtl/bdq_pkg.sv */
// ----------------------------------------------------------------------------
// bdq_pkg
// Widths, operation and status codes, and shared types of the bounded deque.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int FUNC_W    = 3;
    localparam int DATA_W    = 32;
    localparam int STATUS_W  = 2;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_TRAVERSE   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_RD,
        S_TRAV
    } state_t;

    // Request from the sequencer to load one result into the output stage.
    typedef struct packed {
        logic                       load;
        logic signed [DATA_W-1:0]   data;
        logic [STATUS_W-1:0]        status;
        logic                       last;
    } rsp_load_t;

endpackage

`default_nettype wire

/* hw/rtl/bdq_if.sv */
// ----------------------------------------------------------------------------
// bdq_if
// Valid/ready channel interfaces for the deque command and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdq_cmd_if;
    logic                               valid;
    logic                               ready;
    logic [bdq_pkg::FUNC_W-1:0]         func;
    logic signed [bdq_pkg::DATA_W-1:0]  value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface bdq_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [bdq_pkg::DATA_W-1:0]  data;
    logic [bdq_pkg::STATUS_W-1:0]       status;
    logic                               last;

    modport source (output valid, output data, output status, output last, input ready);
    modport sink   (input valid, input data, input status, input last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bdq_ram.sv */
// ----------------------------------------------------------------------------
// bdq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ram #(
    parameter int WIDTH = bdq_pkg::DATA_W,
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // Read data holds until the next read.
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/bdq_ctrl.sv */
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer: ring pointers, occupancy, front value cache and RAM accesses.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ctrl #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    bdq_cmd_if.sink                            cmd,
    input  wire logic                          out_free,
    output bdq_pkg::rsp_load_t                 ld,
    output logic                               mem_we,
    output logic [$clog2(DEPTH)-1:0]           mem_waddr,
    output logic [bdq_pkg::DATA_W-1:0]         mem_wdata,
    output logic                               mem_re,
    output logic [$clog2(DEPTH)-1:0]           mem_raddr,
    input  wire logic [bdq_pkg::DATA_W-1:0]    mem_rdata,
    output logic [$clog2(DEPTH+1)-1:0]         occ
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] SUM_WRAP = SUM_W'(DEPTH);

    bdq_pkg::state_t                   state_reg, state_next;
    logic [IDX_W-1:0]                  front_reg, front_next;
    logic [CNT_W-1:0]                  occ_reg, occ_next;
    logic [IDX_W-1:0]                  ptr_reg, ptr_next;
    logic [CNT_W-1:0]                  left_reg, left_next;
    logic signed [bdq_pkg::DATA_W-1:0] fval_reg, fval_next;

    logic [IDX_W-1:0] front_inc;
    logic [IDX_W-1:0] front_dec;
    logic [IDX_W-1:0] ptr_inc;
    logic [SUM_W-1:0] back_sum;
    logic [IDX_W-1:0] back_idx;
    logic             is_empty;
    logic             is_full;

    assign front_inc = (front_reg == IDX_LAST) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? IDX_LAST : front_reg - 1'b1;
    assign ptr_inc   = (ptr_reg == IDX_LAST) ? '0 : ptr_reg + 1'b1;
    assign back_sum  = SUM_W'(front_reg) + SUM_W'(occ_reg);
    assign back_idx  = (back_sum >= SUM_WRAP) ? IDX_W'(back_sum - SUM_WRAP)
                                              : back_sum[IDX_W-1:0];
    assign is_empty  = (occ_reg == '0);
    assign is_full   = (occ_reg == CNT_FULL);
    assign occ       = occ_reg;

    always_comb
    begin
        state_next = state_reg;
        front_next = front_reg;
        occ_next   = occ_reg;
        ptr_next   = ptr_reg;
        left_next  = left_reg;
        fval_next  = fval_reg;
        ld         = '0;
        mem_we     = 1'b0;
        mem_waddr  = front_reg;
        mem_wdata  = cmd.value;
        mem_re     = 1'b0;
        mem_raddr  = front_reg;
        cmd.ready  = 1'b0;

        unique case (state_reg)
            bdq_pkg::S_IDLE:
            begin
                cmd.ready = out_free;
                if (cmd.valid && out_free)
                begin
                    unique case (cmd.func)
                        bdq_pkg::FN_PUSH_FRONT, bdq_pkg::FN_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                ld.load   = 1'b1;
                                ld.data   = fval_reg;
                                ld.status = bdq_pkg::ST_FULL;
                                ld.last   = 1'b1;
                            end
                            else
                            begin
                                mem_we   = 1'b1;
                                occ_next = occ_reg + 1'b1;
                                if (cmd.func == bdq_pkg::FN_PUSH_FRONT)
                                begin
                                    mem_waddr  = front_dec;
                                    front_next = front_dec;
                                    fval_next  = cmd.value;
                                end
                                else
                                begin
                                    mem_waddr = back_idx;
                                    if (is_empty)
                                    begin
                                        fval_next = cmd.value;
                                    end
                                end
                                ld.load   = 1'b1;
                                ld.data   = fval_next;
                                ld.status = bdq_pkg::ST_OK;
                                ld.last   = 1'b1;
                            end
                        end
                        bdq_pkg::FN_TRAVERSE:
                        begin
                            if (is_empty)
                            begin
                                ld.load   = 1'b1;
                                ld.status = bdq_pkg::ST_EMPTY;
                                ld.last   = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = front_reg;
                                ptr_next   = front_inc;
                                left_next  = occ_reg;
                                state_next = bdq_pkg::S_TRAV;
                            end
                        end
                        bdq_pkg::FN_POP_FRONT:
                        begin
                            if (is_empty || occ_reg == CNT_W'(1))
                            begin
                                // Popping the only entry also reports empty.
                                ld.load   = 1'b1;
                                ld.status = bdq_pkg::ST_EMPTY;
                                ld.last   = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = front_inc;
                                state_next = bdq_pkg::S_POP_RD;
                            end
                            if (!is_empty)
                            begin
                                front_next = front_inc;
                                occ_next   = occ_reg - 1'b1;
                            end
                        end
                        bdq_pkg::FN_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                ld.load   = 1'b1;
                                ld.status = bdq_pkg::ST_EMPTY;
                                ld.last   = 1'b1;
                            end
                            else
                            begin
                                occ_next = occ_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            // Unused codes are consumed without effect.
                        end
                    endcase
                end
            end
            bdq_pkg::S_POP_RD:
            begin
                if (out_free)
                begin
                    ld.load    = 1'b1;
                    ld.data    = mem_rdata;
                    ld.status  = bdq_pkg::ST_OK;
                    ld.last    = 1'b1;
                    fval_next  = mem_rdata;
                    state_next = bdq_pkg::S_IDLE;
                end
            end
            bdq_pkg::S_TRAV:
            begin
                if (out_free)
                begin
                    ld.load   = 1'b1;
                    ld.data   = mem_rdata;
                    ld.status = bdq_pkg::ST_OK;
                    ld.last   = (left_reg == CNT_W'(1));
                    left_next = left_reg - 1'b1;
                    if (left_reg == CNT_W'(1))
                    begin
                        state_next = bdq_pkg::S_IDLE;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = ptr_reg;
                        ptr_next  = ptr_inc;
                    end
                end
            end
            default:
            begin
                state_next = bdq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdq_pkg::S_IDLE;
            front_reg <= '0;
            occ_reg   <= '0;
            ptr_reg   <= '0;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            occ_reg   <= occ_next;
            ptr_reg   <= ptr_next;
            left_reg  <= left_next;
        end
    end

    // Front value cache; only read while the deque holds entries.
    always_ff @(posedge clk)
    begin
        fval_reg <= fval_next;
    end

endmodule

`default_nettype wire

/* hw/rtl/bdq_out.sv */
// ----------------------------------------------------------------------------
// bdq_out
// Output register stage for result items.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_out (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bdq_pkg::rsp_load_t ld,
    output logic                    out_free,
    bdq_rsp_if.source               rsp
);

    logic                              valid_reg;
    logic signed [bdq_pkg::DATA_W-1:0] data_reg;
    logic [bdq_pkg::STATUS_W-1:0]      status_reg;
    logic                              last_reg;

    // The stage can take a new item when empty or when its item leaves now.
    assign out_free = !valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            valid_reg <= ld.load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && ld.load)
        begin
            data_reg   <= ld.data;
            status_reg <= ld.status;
            last_reg   <= ld.last;
        end
    end

    assign rsp.valid  = valid_reg;
    assign rsp.data   = data_reg;
    assign rsp.status = status_reg;
    assign rsp.last   = last_reg;

endmodule

`default_nettype wire

/* hw/rtl/bounded_deque_with_readout_top.sv */
// ----------------------------------------------------------------------------
// bounded_deque_with_readout_top
// Bounded double-ended queue in a ring RAM with a front-to-back readout.
// ----------------------------------------------------------------------------
// The cmd channel takes one item per operation: func selects push front,
// push back, traverse, pop front or pop back, and value is the word to push.
// The rsp channel returns result items with data, status and last.
// Pushes, empty pops, full pushes and empty traversals produce their single
// result in the cycle after acceptance. A pop back that succeeds produces no
// result and unused function codes are consumed silently. A pop front that
// leaves entries behind reads the new front from the ring RAM into the RAM's
// read register and then loads it into the output register once that is free.
// A traversal reads one entry per cycle from the RAM's single read port while
// the output register is free, so it answers with N results, one per cycle
// while the receiver is ready, with last set on the final one. A new command
// is taken only when the sequencer is idle and the output register is free.
// Pushes and pop backs take one item per cycle while the output register is
// free; pop fronts and traversals that read the RAM keep the sequencer busy.
// When the receiver holds ready low, the output register keeps its item and
// the sequencer waits; nothing is lost or repeated. Reset empties the deque
// at once (front index and occupancy cleared); RAM contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_with_readout_top #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    bdq_cmd_if.sink   cmd,
    bdq_rsp_if.source rsp
);

`include "bounded_deque_with_readout_top_macros.svh"

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bdq_pkg::rsp_load_t          ld;
    logic                        out_free;
    logic                        mem_we;
    logic [IDX_W-1:0]            mem_waddr;
    logic [bdq_pkg::DATA_W-1:0]  mem_wdata;
    logic                        mem_re;
    logic [IDX_W-1:0]            mem_raddr;
    logic [bdq_pkg::DATA_W-1:0]  mem_rdata;
    logic [CNT_W-1:0]            occ;

    // The ring store holds every entry; the sequencer owns both RAM ports.
    bdq_ram #(
        .WIDTH (bdq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bdq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .out_free  (out_free),
        .ld        (ld),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .occ       (occ)
    );

    // Output register decouples the sequencer from receiver stalls.
    bdq_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .ld       (ld),
        .out_free (out_free),
        .rsp      (rsp)
    );

    // A result is only loaded when the output register can take it.
    `BDQ_ASSERT_NOW(a_load_has_room, ld.load, out_free,
        "result loaded into a busy output stage")

    // Occupancy never exceeds the ring size.
    `BDQ_ASSERT_NOW(a_occ_bounded, 1'b1, occ <= CNT_W'(DEPTH),
        "occupancy above ring size")

    // A pop back on a non-empty deque removes exactly one entry.
    `BDQ_ASSERT_NEXT(a_pop_back_dec,
        cmd.valid && cmd.ready && cmd.func == bdq_pkg::FN_POP_BACK && occ != '0,
        occ == $past(occ) - 1'b1,
        "pop back did not shrink occupancy")

endmodule

`default_nettype wire

/* tb/bounded_deque_with_readout_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_deque_with_readout_top_tb
// Self-checking bench for the bounded deque. Directed items from a table and
// then random push/pop/traverse traffic go through the command channel under
// random gaps and receiver stalls. The shadow deque and the typed table rows
// predict every result item; each is compared field by field as it arrives.
// ----------------------------------------------------------------------------

module bounded_deque_with_readout_top_tb;

    import bdq_pkg::*;

    localparam int RING_DEPTH = DEPTH_DEF;

    // Function codes that the block must swallow without a result.
    localparam logic [FUNC_W-1:0] FN_RSVD_5 = 3'd5;
    localparam logic [FUNC_W-1:0] FN_RSVD_7 = 3'd7;

    localparam int RANDOM_ITEMS = 340;
    localparam int DIRECTED_ROWS = 17;

    // One result item as the rsp channel carries it.
    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [STATUS_W-1:0]      status;
        logic                     last;
    } answer_t;

    // One row of the directed table. A row with reps > 1 sends the same
    // operation several times, with the value stepping up by one each time.
    // Rows with typed set carry their single expected result inline.
    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [DATA_W-1:0]   value;
        int                  reps;
        bit                  typed;
        logic [DATA_W-1:0]   t_data;
        logic [STATUS_W-1:0] t_status;
    } stim_row_t;

    logic clk;
    logic rst_n;

    bdq_cmd_if cmd_ch ();
    bdq_rsp_if rsp_ch ();

    bounded_deque_with_readout_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the deque: ring store, front slot and fill count.
    logic [DATA_W-1:0] shadow_ring [RING_DEPTH];
    logic [3:0]        shadow_front;
    logic [4:0]        shadow_count;

    // Result items that the block still owes, oldest first.
    answer_t pending_answers [$];

    int  err_count;
    // While set, neither side of the bench inserts gaps or stalls.
    bit  steady;

    stim_row_t directed_rows [DIRECTED_ROWS];

    // ------------------------------------------------------------------------
    // Clock and the overall time limit.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Well beyond the slowest legal run: every item a full traversal, every
    // result stalled by the receiver, every command delayed by the sender.
    initial
    begin
        #2_000_000;
        $display("bounded_deque_with_readout_top_tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Shadow deque. Applies one accepted command to the shadow state and,
    // when publish is set, queues the result items it must cause. Rows whose
    // result is typed into the table only advance the state here.
    // ------------------------------------------------------------------------
    function automatic logic [DATA_W-1:0] shadow_front_word();
        return (shadow_count != 0) ? shadow_ring[shadow_front] : '0;
    endfunction

    function automatic void apply_to_shadow_deque(input logic [FUNC_W-1:0] f,
                                                  input logic [DATA_W-1:0] v,
                                                  input bit publish);
        answer_t    outs [$];
        logic [3:0] slot;
        int         i;
        case (f)
            FN_PUSH_FRONT, FN_PUSH_BACK:
            begin
                if (shadow_count >= RING_DEPTH)
                begin
                    // A full store drops the item but still reports the front.
                    outs.push_back('{data: shadow_front_word(), status: ST_FULL,
                                     last: 1'b1});
                end
                else
                begin
                    if (f == FN_PUSH_FRONT)
                    begin
                        shadow_front = shadow_front - 4'd1;
                        shadow_ring[shadow_front] = v;
                    end
                    else
                    begin
                        slot = shadow_front + shadow_count[3:0];
                        shadow_ring[slot] = v;
                    end
                    shadow_count = shadow_count + 5'd1;
                    outs.push_back('{data: shadow_front_word(), status: ST_OK,
                                     last: 1'b1});
                end
            end
            FN_TRAVERSE:
            begin
                if (shadow_count == 0)
                begin
                    outs.push_back('{data: '0, status: ST_EMPTY, last: 1'b1});
                end
                else
                begin
                    for (i = 0; i < shadow_count; i++)
                    begin
                        slot = shadow_front + i[3:0];
                        outs.push_back('{data: shadow_ring[slot], status: ST_OK,
                                         last: (i == shadow_count - 1)});
                    end
                end
            end
            FN_POP_FRONT:
            begin
                if (shadow_count != 0)
                begin
                    shadow_front = shadow_front + 4'd1;
                    shadow_count = shadow_count - 5'd1;
                end
                // Emptying the store by a pop front reads like an empty pop.
                if (shadow_count == 0)
                    outs.push_back('{data: '0, status: ST_EMPTY, last: 1'b1});
                else
                    outs.push_back('{data: shadow_front_word(), status: ST_OK,
                                     last: 1'b1});
            end
            FN_POP_BACK:
            begin
                // A pop back that removes an entry answers nothing at all.
                if (shadow_count == 0)
                    outs.push_back('{data: '0, status: ST_EMPTY, last: 1'b1});
                else
                    shadow_count = shadow_count - 5'd1;
            end
            default:
            begin
                // Unused codes are consumed with no effect.
            end
        endcase
        if (publish)
            foreach (outs[k])
                pending_answers.push_back(outs[k]);
    endfunction

    // ------------------------------------------------------------------------
    // Command side. The item is presented with a nonblocking update at the
    // clock edge and held until an edge where ready is seen high. Before it,
    // the sender may leave the channel idle at random unless the bench is steady.
    // ------------------------------------------------------------------------
    task automatic offer_cmd(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] v);
        while (!steady && $urandom_range(0, 99) < 35)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.func  <= f;
        cmd_ch.value <= v;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side. Ready is redrawn every cycle unless the bench is in its
    // steady stretch, so stalls land on every phase of a traversal.
    // ------------------------------------------------------------------------
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 35);
        end
    end

    // Every accepted result item is checked against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        answer_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected result item, expected none, %s",
                         $time, "got:");
                $display("%0t:   data %h status %0d last %0b",
                         $time, rsp_ch.data, rsp_ch.status, rsp_ch.last);
                err_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (rsp_ch.data !== want.data)
                begin
                    $display("%0t: data mismatch, expected %h, got %h",
                             $time, want.data, rsp_ch.data);
                    err_count++;
                end
                if (rsp_ch.status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, rsp_ch.status);
                    err_count++;
                end
                if (rsp_ch.last !== want.last)
                begin
                    $display("%0t: last mismatch, expected %0b, got %0b",
                             $time, want.last, rsp_ch.last);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed table, random traffic, drain and verdict.
    // ------------------------------------------------------------------------
    initial
    begin
        int                  r;
        int                  n;
        int                  phase_left;
        bit                  filling;
        logic [FUNC_W-1:0]   f;
        logic [DATA_W-1:0]   v;

        err_count    = 0;
        steady       = 1'b0;
        shadow_front = '0;
        shadow_count = '0;
        foreach (shadow_ring[k])
            shadow_ring[k] = '0;

        // The directed part walks the corners: every empty-store case first,
        // then the extreme values, an emptying pop front, a fill to capacity
        // with a push front that wraps the ring, pushes into a full store, a
        // full-length traversal and the ignored codes.
        directed_rows = '{
            '{FN_POP_FRONT,  32'h0000_0000,  1, 1'b1, 32'h0000_0000, ST_EMPTY},
            '{FN_POP_BACK,   32'hFFFF_FFFF,  1, 1'b1, 32'h0000_0000, ST_EMPTY},
            '{FN_TRAVERSE,   32'h0000_0000,  1, 1'b1, 32'h0000_0000, ST_EMPTY},
            '{FN_RSVD_7,     32'h5555_5555,  1, 1'b0, 32'h0000_0000, ST_OK},
            '{FN_PUSH_FRONT, 32'h8000_0000,  1, 1'b1, 32'h8000_0000, ST_OK},
            '{FN_PUSH_BACK,  32'h7FFF_FFFF,  1, 1'b1, 32'h8000_0000, ST_OK},
            '{FN_TRAVERSE,   32'hAAAA_AAAA,  1, 1'b0, 32'h0000_0000, ST_OK},
            '{FN_POP_BACK,   32'h0000_0000,  1, 1'b0, 32'h0000_0000, ST_OK},
            '{FN_POP_FRONT,  32'h0000_0000,  1, 1'b1, 32'h0000_0000, ST_EMPTY},
            '{FN_PUSH_BACK,  32'hFFFF_FFFF,  1, 1'b1, 32'hFFFF_FFFF, ST_OK},
            '{FN_PUSH_FRONT, 32'h0000_0000,  1, 1'b1, 32'h0000_0000, ST_OK},
            '{FN_PUSH_BACK,  32'h5A5A_0000, 14, 1'b0, 32'h0000_0000, ST_OK},
            '{FN_PUSH_FRONT, 32'h0000_0001,  1, 1'b1, 32'h0000_0000, ST_FULL},
            '{FN_PUSH_BACK,  32'h0000_0002,  1, 1'b1, 32'h0000_0000, ST_FULL},
            '{FN_TRAVERSE,   32'h0000_0000,  1, 1'b0, 32'h0000_0000, ST_OK},
            '{FN_POP_FRONT,  32'h0000_0000,  1, 1'b0, 32'h0000_0000, ST_OK},
            '{FN_RSVD_5,     32'h0000_0000,  1, 1'b0, 32'h0000_0000, ST_OK}
        };

        rst_n        <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.func  <= FN_PUSH_FRONT;
        cmd_ch.value <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[row])
        begin
            for (n = 0; n < directed_rows[row].reps; n++)
            begin
                v = directed_rows[row].value + n;
                offer_cmd(directed_rows[row].func, v);
                apply_to_shadow_deque(directed_rows[row].func, v,
                                      !directed_rows[row].typed);
                if (directed_rows[row].typed)
                    pending_answers.push_back('{data: directed_rows[row].t_data,
                                                status: directed_rows[row].t_status,
                                                last: 1'b1});
            end
        end

        // Random traffic alternates between filling and draining stretches so
        // that the store keeps swinging between empty and full, with pushes
        // and pops at both ends and traversals of every length in between.
        filling    = 1'b1;
        phase_left = 0;
        n          = 0;
        while (n < RANDOM_ITEMS)
        begin
            if (phase_left == 0)
            begin
                filling    = !filling;
                phase_left = $urandom_range(12, 40);
            end
            phase_left--;

            // One long stretch with no gaps or stalls on either side.
            steady = (n >= 120 && n < 200);

            r = $urandom_range(0, 99);
            if (r < (filling ? 60 : 25))
                f = $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
            else if (r < (filling ? 82 : 85))
                f = $urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT;
            else if (r < 97)
                f = FN_TRAVERSE;
            else
                f = $urandom_range(FN_RSVD_7, FN_RSVD_5);
            v = $urandom;

            offer_cmd(f, v);
            apply_to_shadow_deque(f, v, 1'b1);
            // Ignored codes do not count toward the random item budget.
            if (f <= FN_POP_BACK)
                n++;
        end

        cmd_ch.valid <= 1'b0;
        steady = 1'b0;

        // Let every owed result arrive, then keep waiting with no traffic so that a
        // stray extra result would still be caught.
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (err_count == 0)
            $display("bounded_deque_with_readout_top_tb: clean");
        else
            $display("bounded_deque_with_readout_top_tb: errors");
        $finish;
    end

endmodule
